/* hw/rtl/strmi_pkg.sv */
// ----------------------------------------------------------------------------
// strmi_pkg
// Shared codes, field widths and command type for the sparse table
// range-maximum block.
// ----------------------------------------------------------------------------
package strmi_pkg;

  // fixed field widths of the channels
  localparam int REQ_W     = 2;
  localparam int POS_W     = 10;
  localparam int IN_VAL_W  = 32;
  localparam int CFG_W     = 11;
  localparam int STATUS_W  = 2;
  localparam int OUT_VAL_W = 32;
  localparam int OUT_IDX_W = 10;

  localparam logic [CFG_W-1:0] ELEM_COUNT_RST = 11'd1024;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd2;

  // work handed from front to back
  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_BUILD = 2'd1;
  localparam op_t OP_QUERY = 2'd2;
  localparam op_t OP_REPLY = 2'd3;

  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // width that holds the element count, the configured count and the widest window
  function automatic int cnt_width(input int max_elems, input int num_levels);
    int w;
    w = $clog2(max_elems) + 1;
    if (num_levels > w) w = num_levels;
    if (CFG_W > w) w = CFG_W;
    return w;
  endfunction

endpackage

/* hw/rtl/sparse_table_range_max_index_top.sv */
// ----------------------------------------------------------------------------
// sparse_table_range_max_index_top
// Sparse table range-maximum engine returning value and position.
// ----------------------------------------------------------------------------
// Usage: requests enter on the in_ channel (valid/stall). req_type 0 loads
// in_value at in_position, 1 builds all power-of-two levels over the active
// element count, 2 queries [in_position, in_right_end]. Every request yields
// exactly one beat on the out_ channel (valid/stall) with status, max_value
// and max_index. The user writes the element count via cfg_ (valid/ready, always
// ready) only while the block is idle, unchecked; a write clears the built flag.
// Timing: a two-entry queue separates the front end from the back end, so the
// front keeps accepting until the queue is full while the back works or the
// receiver stalls. Loads and error replies go straight to the result register.
// A query reads both table ports together, then compares and registers the
// result. A build sweeps each level through the single table write port, one
// entry per cycle, with a drain step between levels.
// Reset clears the queue, the built flag and the result valid flag and sets the
// element count to 1024; table contents are undefined until loaded.
// A stalled result holds; the back end then waits and the queue fills.
// ----------------------------------------------------------------------------
module sparse_table_range_max_index_top import strmi_pkg::*; #(
  parameter int MAX_ELEMS   = 1024,
  parameter int NUM_LEVELS  = 11,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [REQ_W-1:0]            in_req_type,
  input  logic [POS_W-1:0]            in_position,
  input  logic [POS_W-1:0]            in_right_end,
  input  logic signed [IN_VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [STATUS_W-1:0]         out_status,
  output logic signed [OUT_VAL_W-1:0] out_max_value,
  output logic [OUT_IDX_W-1:0]        out_max_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_W-1:0]            cfg_elem_count
);

  localparam int AW     = $clog2(NUM_LEVELS) + $clog2(MAX_ELEMS);
  localparam int CW     = cnt_width(MAX_ELEMS, NUM_LEVELS);
  localparam int FIFO_W = $bits(cmd_t) + 2 * AW + VALUE_WIDTH;

  logic                   push;
  logic                   pop;
  logic                   q_full;
  logic                   q_empty;
  cmd_t                   push_cmd;
  logic [AW-1:0]          push_addr_a;
  logic [AW-1:0]          push_addr_b;
  logic [VALUE_WIDTH-1:0] push_value;
  cmd_t                   pop_cmd;
  logic [AW-1:0]          pop_addr_a;
  logic [AW-1:0]          pop_addr_b;
  logic [VALUE_WIDTH-1:0] pop_value;
  logic [FIFO_W-1:0]      fifo_wr;
  logic [FIFO_W-1:0]      fifo_rd;
  logic [CW-1:0]          active_count;
  logic [OUT_VAL_W-1:0]   back_value;

  strmi_front #(
    .MAX_ELEMS   (MAX_ELEMS),
    .NUM_LEVELS  (NUM_LEVELS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_right_end   (in_right_end),
    .in_value       (in_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_elem_count (cfg_elem_count),
    .q_full         (q_full),
    .q_push         (push),
    .q_cmd          (push_cmd),
    .q_addr_a       (push_addr_a),
    .q_addr_b       (push_addr_b),
    .q_value        (push_value),
    .active_count   (active_count)
  );

  assign fifo_wr = {push_cmd, push_addr_a, push_addr_b, push_value};
  assign {pop_cmd, pop_addr_a, pop_addr_b, pop_value} = fifo_rd;

  strmi_fifo #(
    .WIDTH (FIFO_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (fifo_wr),
    .pop     (pop),
    .rd_data (fifo_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  strmi_back #(
    .MAX_ELEMS   (MAX_ELEMS),
    .NUM_LEVELS  (NUM_LEVELS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (!q_empty),
    .q_pop        (pop),
    .q_cmd        (pop_cmd),
    .q_addr_a     (pop_addr_a),
    .q_addr_b     (pop_addr_b),
    .q_value      (pop_value),
    .active_count (active_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_value    (back_value),
    .out_index    (out_max_index)
  );

  assign out_max_value = back_value;

endmodule

/* hw/rtl/strmi_front.sv */
// ----------------------------------------------------------------------------
// strmi_front
// Accepts requests, holds the element count register and the built flag,
// checks ranges and turns each request into a command for the back end.
// ----------------------------------------------------------------------------
module strmi_front import strmi_pkg::*; #(
  parameter int MAX_ELEMS   = 1024,
  parameter int NUM_LEVELS  = 11,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [REQ_W-1:0]              in_req_type,
  input  logic [POS_W-1:0]              in_position,
  input  logic [POS_W-1:0]              in_right_end,
  input  logic signed [IN_VAL_W-1:0]    in_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_elem_count,
  input  logic                          q_full,
  output logic                          q_push,
  output cmd_t                          q_cmd,
  output logic [$clog2(NUM_LEVELS)+$clog2(MAX_ELEMS)-1:0] q_addr_a,
  output logic [$clog2(NUM_LEVELS)+$clog2(MAX_ELEMS)-1:0] q_addr_b,
  output logic [VALUE_WIDTH-1:0]        q_value,
  output logic [cnt_width(MAX_ELEMS, NUM_LEVELS)-1:0] active_count
);

  localparam int IW = $clog2(MAX_ELEMS);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int CW = cnt_width(MAX_ELEMS, NUM_LEVELS);

  logic [CFG_W-1:0] elem_count_r;
  logic             built_r;
  logic             built_nxt;
  logic             in_acc;

  logic [CW-1:0] left_c;
  logic [CW-1:0] right_c;
  logic [CW-1:0] len_c;
  logic [CW-1:0] span_c;
  logic [CW-1:0] right_start_c;
  logic [LW-1:0] lg;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_acc    = in_valid && !q_full;
  assign q_push    = in_acc;

  assign active_count = (CW'(elem_count_r) > CW'(MAX_ELEMS)) ? CW'(MAX_ELEMS)
                                                             : CW'(elem_count_r);

  assign left_c  = CW'(in_position);
  assign right_c = CW'(in_right_end);
  assign len_c   = right_c - left_c + CW'(1);

  // level = floor(log2(len)), capped at the top level
  always_comb begin
    lg = '0;
    for (int k = 1; k < NUM_LEVELS; k++) begin
      if ((len_c >> k) != '0) lg = LW'(k);
    end
  end

  assign span_c        = CW'(1) << lg;
  assign right_start_c = right_c + CW'(1) - span_c;

  // sign-extend the loaded value to the stored width
  assign q_value = VALUE_WIDTH'(in_value);

  always_comb begin
    q_cmd.op     = OP_REPLY;
    q_cmd.status = STAT_RANGE_ERR;
    q_addr_a     = '0;
    q_addr_b     = '0;
    unique case (in_req_type)
      REQ_LOAD: begin
        if (left_c < CW'(MAX_ELEMS)) begin
          q_cmd.op     = OP_LOAD;
          q_cmd.status = STAT_OK;
          q_addr_a     = {LW'(0), IW'(left_c)};
        end
      end
      REQ_BUILD: begin
        q_cmd.op     = OP_BUILD;
        q_cmd.status = STAT_OK;
      end
      REQ_QUERY: begin
        if (left_c > right_c || right_c >= active_count) begin
          q_cmd.status = STAT_RANGE_ERR;
        end else if (!built_r) begin
          q_cmd.status = STAT_NOT_BUILT;
        end else begin
          q_cmd.op     = OP_QUERY;
          q_cmd.status = STAT_OK;
          q_addr_a     = {lg, IW'(left_c)};
          q_addr_b     = {lg, IW'(right_start_c)};
        end
      end
      default: begin
        q_cmd.status = STAT_RANGE_ERR;
      end
    endcase
  end

  // the built flag follows request order, so it is tracked here at accept time
  always_comb begin
    built_nxt = built_r;
    if (cfg_valid) begin
      built_nxt = 1'b0;
    end else if (in_acc) begin
      if (q_cmd.op == OP_LOAD) built_nxt = 1'b0;
      if (q_cmd.op == OP_BUILD) built_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_count_r <= ELEM_COUNT_RST;
      built_r      <= 1'b0;
    end else begin
      if (cfg_valid) elem_count_r <= cfg_elem_count;
      built_r <= built_nxt;
    end
  end

endmodule

/* hw/rtl/strmi_fifo.sv */
// ----------------------------------------------------------------------------
// strmi_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module strmi_fifo import strmi_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

/* hw/rtl/strmi_back.sv */
// ----------------------------------------------------------------------------
// strmi_back
// Executes commands against the level table: base loads, the level-by-level
// build sweep and two-port range queries; holds the result register.
// ----------------------------------------------------------------------------
module strmi_back import strmi_pkg::*; #(
  parameter int MAX_ELEMS   = 1024,
  parameter int NUM_LEVELS  = 11,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  cmd_t                          q_cmd,
  input  logic [$clog2(NUM_LEVELS)+$clog2(MAX_ELEMS)-1:0] q_addr_a,
  input  logic [$clog2(NUM_LEVELS)+$clog2(MAX_ELEMS)-1:0] q_addr_b,
  input  logic [VALUE_WIDTH-1:0]        q_value,
  input  logic [cnt_width(MAX_ELEMS, NUM_LEVELS)-1:0] active_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [STATUS_W-1:0]           out_status,
  output logic [OUT_VAL_W-1:0]          out_value,
  output logic [OUT_IDX_W-1:0]          out_index
);

  localparam int IW        = $clog2(MAX_ELEMS);
  localparam int LW        = $clog2(NUM_LEVELS);
  localparam int CW        = cnt_width(MAX_ELEMS, NUM_LEVELS);
  localparam int SW        = CW + 1;
  localparam int AW        = LW + IW;
  localparam int EW        = VALUE_WIDTH + IW;
  localparam int MEM_DEPTH = NUM_LEVELS << IW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QWAIT = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // entry = {value, index}
  logic [EW-1:0] level_mem [MEM_DEPTH];
  logic [EW-1:0] rd_a_r;
  logic [EW-1:0] rd_b_r;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] win_r, win_nxt;
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;

  logic          out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [OUT_VAL_W-1:0] out_value_r;
  logic [OUT_IDX_W-1:0] out_index_r;

  logic          out_free;
  logic          rd_en;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] best_entry;
  logic          res_load;
  logic [STATUS_W-1:0] res_status;
  logic [EW-1:0] res_entry;

  // larger value wins, larger index on equal values
  function automatic logic [EW-1:0] pick_max(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic signed [VALUE_WIDTH-1:0] va;
    logic signed [VALUE_WIDTH-1:0] vb;
    logic [IW-1:0] ia;
    logic [IW-1:0] ib;
    logic          b_wins;
    va = a[EW-1:IW];
    vb = b[EW-1:IW];
    ia = a[IW-1:0];
    ib = b[IW-1:0];
    b_wins = (va < vb) || (va == vb && ia < ib);
    return b_wins ? b : a;
  endfunction

  assign best_entry = pick_max(rd_a_r, rd_b_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    lvl_nxt    = lvl_r;
    idx_nxt    = idx_r;
    win_nxt    = win_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr_a  = '0;
    rd_addr_b  = '0;
    mem_we     = wr_pend_r;
    mem_waddr  = wr_addr_r;
    mem_wdata  = best_entry;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_entry  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_LOAD: begin
              if (out_free) begin
                q_pop      = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = q_addr_a;
                mem_wdata  = {q_value, q_addr_a[IW-1:0]};
                res_load   = 1'b1;
                res_status = q_cmd.status;
              end
            end
            OP_REPLY: begin
              if (out_free) begin
                q_pop      = 1'b1;
                res_load   = 1'b1;
                res_status = q_cmd.status;
              end
            end
            OP_QUERY: begin
              q_pop     = 1'b1;
              rd_en     = 1'b1;
              rd_addr_a = q_addr_a;
              rd_addr_b = q_addr_b;
              state_nxt = ST_QWAIT;
            end
            OP_BUILD: begin
              q_pop     = 1'b1;
              lvl_nxt   = LW'(1);
              idx_nxt   = '0;
              win_nxt   = CW'(2);
              state_nxt = (active_count >= CW'(2)) ? ST_ISSUE : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_QWAIT: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_entry = best_entry;
          state_nxt = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        // read the two halves from the level below, write lands next cycle
        rd_en     = 1'b1;
        rd_addr_a = {lvl_r - LW'(1), idx_r};
        rd_addr_b = {lvl_r - LW'(1), IW'(CW'(idx_r) + (win_r >> 1))};
        if (SW'(idx_r) + SW'(1) + SW'(win_r) <= SW'(active_count)) begin
          idx_nxt = idx_r + IW'(1);
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write of the level completes here before the next level reads it
        if (lvl_r != LW'(NUM_LEVELS - 1) &&
            (SW'(win_r) << 1) <= SW'(active_count)) begin
          lvl_nxt   = lvl_r + LW'(1);
          win_nxt   = win_r << 1;
          idx_nxt   = '0;
          state_nxt = ST_ISSUE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) level_mem[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      rd_a_r <= level_mem[rd_addr_a];
      rd_b_r <= level_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      idx_r       <= '0;
      win_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lvl_r     <= lvl_nxt;
      idx_r     <= idx_nxt;
      win_r     <= win_nxt;
      wr_pend_r <= (state_r == ST_ISSUE);
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= {lvl_r, idx_r};
    if (res_load) begin
      out_status_r <= res_status;
      out_value_r  <= OUT_VAL_W'(res_entry[EW-1:IW]);
      out_index_r  <= OUT_IDX_W'(res_entry[IW-1:0]);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_index  = out_index_r;

`ifndef SYNTHESIS
  a_load_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_cmd.op == OP_LOAD) |-> !wr_pend_r)
    else $error("load write collides with build write");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_sweep_in_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |->
      (lvl_r != '0) && (SW'(idx_r) + SW'(win_r) <= SW'(active_count)))
    else $error("build sweep reads outside the level");

  a_drain_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> wr_pend_r)
    else $error("level drain without pending write");
`endif

endmodule
